FILE: hw/rtl/counter_based_random_hash_defines.svh
// Assertion macros for the counter-based random hash checker.
// Included by the checker file only; no other dependencies.
`ifndef COUNTER_BASED_RANDOM_HASH_DEFINES_SVH
`define COUNTER_BASED_RANDOM_HASH_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define CRH_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CRH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/crh_pkg.sv
// Package for the counter-based random hash: widths, mixer constants,
// pipeline depths and register indexes. No dependencies.
`timescale 1ns / 1ps

package crh_pkg;

    // Field widths
    localparam int DATA_W   = 64;
    localparam int HALF_W   = 32;
    localparam int STREAM_W = 32;
    localparam int S_TDATA_W = STREAM_W + 3 * DATA_W;

    // Mixer constants
    localparam logic [DATA_W-1:0] GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [DATA_W-1:0] MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [DATA_W-1:0] MIX_MUL_B    = 64'h94D049BB133111EB;

    // Per-field domain salts
    localparam logic [DATA_W-1:0] TICK_SALT    = 64'h5449434B5F563031;
    localparam logic [DATA_W-1:0] ENTITY_SALT  = 64'h535441424C455F49;
    localparam logic [DATA_W-1:0] ORDINAL_SALT = 64'h4F5244494E414C31;

    // One mixer round takes this many register stages
    localparam int MIX_LAT = 5;
    // Five rounds in series on the main chain
    localparam int MIX_CHAIN = 5;
    localparam int PIPE_DEPTH = MIX_LAT * MIX_CHAIN;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_WORLD_SEED   = 1'b0,
        CFG_ALGORITHM_ID = 1'b1
    } cfg_index_t;

endpackage

FILE: hw/rtl/crh_skid.sv
// Input skid stage for the counter-based random hash.
// Depends on crh_pkg for the input item width.
`timescale 1ns / 1ps

module crh_skid (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [crh_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           en,
    output logic                           pipe_valid,
    output logic [crh_pkg::S_TDATA_W-1:0]  pipe_data
);

    logic                          skid_valid_reg;
    logic                          skid_valid_next;
    logic [crh_pkg::S_TDATA_W-1:0] skid_data_reg;
    logic [crh_pkg::S_TDATA_W-1:0] skid_data_next;

    // Ready is a register: it only drops while the skid slot is full
    assign s_tready   = !skid_valid_reg;
    assign pipe_valid = skid_valid_reg || s_tvalid;
    assign pipe_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    // Drain on advance, catch an item that arrives during a stall
    always_comb begin
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_tvalid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
            skid_data_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        skid_data_reg <= skid_data_next;
    end

endmodule

FILE: hw/rtl/crh_delay.sv
// Enabled shift line that keeps side values aligned with the main chain.
// No package dependencies.
`timescale 1ns / 1ps

module crh_delay #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 5
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // Advance every tap together on enable
    always_ff @(posedge aclk) begin
        if (en) begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

FILE: hw/rtl/crh_mix.sv
// Five-stage splitmix64 finalizer with each 64-bit multiply split into
// 32-bit partial products. Depends on crh_pkg for constants.
`timescale 1ns / 1ps

module crh_mix (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [crh_pkg::DATA_W-1:0]  x_in,
    output logic [crh_pkg::DATA_W-1:0]  x_out
);

    localparam int W = crh_pkg::DATA_W;
    localparam int H = crh_pkg::HALF_W;

    localparam logic [H-1:0] A_LO = crh_pkg::MIX_MUL_A[H-1:0];
    localparam logic [H-1:0] A_HI = crh_pkg::MIX_MUL_A[W-1:H];
    localparam logic [H-1:0] B_LO = crh_pkg::MIX_MUL_B[H-1:0];
    localparam logic [H-1:0] B_HI = crh_pkg::MIX_MUL_B[W-1:H];

    logic [W-1:0] v1_reg, v1_next;
    logic [W-1:0] t1;
    logic [W-1:0] pa_ll_reg, pa_ll_next;
    logic [H-1:0] pa_lh_reg, pa_lh_next;
    logic [H-1:0] pa_hl_reg, pa_hl_next;
    logic [H-1:0] pa_cross;
    logic [W-1:0] x2_reg, x2_next;
    logic [W-1:0] t2;
    logic [W-1:0] pb_ll_reg, pb_ll_next;
    logic [H-1:0] pb_lh_reg, pb_lh_next;
    logic [H-1:0] pb_hl_reg, pb_hl_next;
    logic [H-1:0] pb_cross;
    logic [W-1:0] x3;
    logic [W-1:0] out_reg, out_next;

    // Stage 1: add the golden-ratio increment
    assign v1_next = x_in + crh_pkg::GOLDEN_GAMMA;

    // Stage 2: xor-shift, then partial products with the first multiplier
    assign t1         = v1_reg ^ (v1_reg >> 30);
    assign pa_ll_next = {{H{1'b0}}, t1[H-1:0]} * {{H{1'b0}}, A_LO};
    assign pa_lh_next = t1[H-1:0] * A_HI;
    assign pa_hl_next = t1[W-1:H] * A_LO;

    // Stage 3: fold partial products into the low 64 bits
    assign pa_cross = pa_lh_reg + pa_hl_reg;
    assign x2_next  = pa_ll_reg + {pa_cross, {H{1'b0}}};

    // Stage 4: xor-shift, then partial products with the second multiplier
    assign t2         = x2_reg ^ (x2_reg >> 27);
    assign pb_ll_next = {{H{1'b0}}, t2[H-1:0]} * {{H{1'b0}}, B_LO};
    assign pb_lh_next = t2[H-1:0] * B_HI;
    assign pb_hl_next = t2[W-1:H] * B_LO;

    // Stage 5: fold and apply the final xor-shift
    assign pb_cross = pb_lh_reg + pb_hl_reg;
    assign x3       = pb_ll_reg + {pb_cross, {H{1'b0}}};
    assign out_next = x3 ^ (x3 >> 31);

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg    <= v1_next;
            pa_ll_reg <= pa_ll_next;
            pa_lh_reg <= pa_lh_next;
            pa_hl_reg <= pa_hl_next;
            x2_reg    <= x2_next;
            pb_ll_reg <= pb_ll_next;
            pb_lh_reg <= pb_lh_next;
            pb_hl_reg <= pb_hl_next;
            out_reg   <= out_next;
        end
    end

    assign x_out = out_reg;

endmodule

FILE: hw/rtl/counter_based_random_hash.sv
// Top level of the counter-based random hash: skid stage, five chained
// mixer rounds plus three side rounds. Depends on crh_pkg, crh_skid,
// crh_delay and crh_mix.
//
//   port group   dir  contents
//   s_*          in   stream_id, tick, stable_id, ordinal (one item)
//   m_*          out  random_value (one item per input item)
//   cfg_*        in   write of world_seed or algorithm_id
//
// One item enters per cycle while the output is not stalled; each result leaves
// after its item passes through five mixer rounds of five stages in series.
// A stall on m_tready freezes the whole pipeline; the skid stage catches
// the one item that may arrive in that cycle, so s_tready is a register.
// Reset clears the valid line, the skid slot and both registers to zero.
`timescale 1ns / 1ps

module counter_based_random_hash (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata from bit 0: stream_id[31:0], tick[63:0], stable_id[63:0],
    // ordinal[63:0]
    input  logic [crh_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata from bit 0: random_value[63:0]
    output logic [crh_pkg::DATA_W-1:0]     m_tdata,
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_index,
    input  logic [crh_pkg::DATA_W-1:0]     cfg_wdata
);

    localparam int W  = crh_pkg::DATA_W;
    localparam int SW = crh_pkg::STREAM_W;
    localparam int ML = crh_pkg::MIX_LAT;
    localparam int PD = crh_pkg::PIPE_DEPTH;

    logic                          en;
    logic                          pipe_valid;
    logic [crh_pkg::S_TDATA_W-1:0] pipe_data;
    logic [SW-1:0]                 in_stream;
    logic [W-1:0]                  in_tick, in_stable, in_ordinal;

    logic [W-1:0] world_seed_reg, world_seed_next;
    logic [W-1:0] algorithm_id_reg, algorithm_id_next;
    logic [PD-1:0] valid_reg, valid_next;

    logic [W-1:0]  acc0, acc1, acc2, acc3, acc4;
    logic [W-1:0]  mix_tick, mix_stable, mix_ordinal;
    logic [W-1:0]  tick_d, stable_d, ordinal_d;
    logic [SW-1:0] stream_d;

    // Whole pipeline advances unless a finished item is held at the output
    assign en = !m_tvalid || m_tready;

    crh_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .en         (en),
        .pipe_valid (pipe_valid),
        .pipe_data  (pipe_data)
    );

    // Unpack the item
    assign in_stream  = pipe_data[SW-1:0];
    assign in_tick    = pipe_data[SW+W-1:SW];
    assign in_stable  = pipe_data[SW+2*W-1:SW+W];
    assign in_ordinal = pipe_data[SW+3*W-1:SW+2*W];

    // Configuration writes
    always_comb begin
        world_seed_next   = world_seed_reg;
        algorithm_id_next = algorithm_id_reg;
        if (cfg_we) begin
            unique case (crh_pkg::cfg_index_t'(cfg_index))
                crh_pkg::CFG_WORLD_SEED:   world_seed_next   = cfg_wdata;
                crh_pkg::CFG_ALGORITHM_ID: algorithm_id_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            world_seed_reg   <= '0;
            algorithm_id_reg <= '0;
        end else begin
            world_seed_reg   <= world_seed_next;
            algorithm_id_reg <= algorithm_id_next;
        end
    end

    // Valid bits travel alongside the mixer stages
    always_comb begin
        valid_next = valid_reg;
        if (en) begin
            valid_next = {valid_reg[PD-2:0], pipe_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Round 0 on the seed, side rounds on the salted counters in parallel
    crh_mix u_mix_seed (
        .aclk (aclk), .en (en),
        .x_in (world_seed_reg ^ algorithm_id_reg), .x_out (acc0)
    );
    crh_mix u_mix_tick (
        .aclk (aclk), .en (en),
        .x_in (in_tick ^ crh_pkg::TICK_SALT), .x_out (mix_tick)
    );
    crh_mix u_mix_stable (
        .aclk (aclk), .en (en),
        .x_in (in_stable ^ crh_pkg::ENTITY_SALT), .x_out (mix_stable)
    );
    crh_mix u_mix_ordinal (
        .aclk (aclk), .en (en),
        .x_in (in_ordinal ^ crh_pkg::ORDINAL_SALT), .x_out (mix_ordinal)
    );

    // Hold side values until their round on the main chain
    crh_delay #(.WIDTH(SW), .DEPTH(ML)) u_dly_stream (
        .aclk (aclk), .en (en), .din (in_stream), .dout (stream_d)
    );
    crh_delay #(.WIDTH(W), .DEPTH(ML)) u_dly_tick (
        .aclk (aclk), .en (en), .din (mix_tick), .dout (tick_d)
    );
    crh_delay #(.WIDTH(W), .DEPTH(2 * ML)) u_dly_stable (
        .aclk (aclk), .en (en), .din (mix_stable), .dout (stable_d)
    );
    crh_delay #(.WIDTH(W), .DEPTH(3 * ML)) u_dly_ordinal (
        .aclk (aclk), .en (en), .din (mix_ordinal), .dout (ordinal_d)
    );

    // Main chain
    crh_mix u_mix_stream (
        .aclk (aclk), .en (en),
        .x_in (acc0 ^ {{(W-SW){1'b0}}, stream_d}), .x_out (acc1)
    );
    crh_mix u_mix_r2 (
        .aclk (aclk), .en (en), .x_in (acc1 ^ tick_d), .x_out (acc2)
    );
    crh_mix u_mix_r3 (
        .aclk (aclk), .en (en), .x_in (acc2 ^ stable_d), .x_out (acc3)
    );
    crh_mix u_mix_r4 (
        .aclk (aclk), .en (en), .x_in (acc3 ^ ordinal_d), .x_out (acc4)
    );

    assign m_tvalid = valid_reg[PD-1];
    assign m_tdata  = acc4;

endmodule

FILE: hw/rtl/crh_checker.sv
// Port-level checker for the counter-based random hash, bound to the top.
// Depends on crh_pkg and counter_based_random_hash_defines.svh.
`timescale 1ns / 1ps
`include "counter_based_random_hash_defines.svh"

module crh_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [crh_pkg::DATA_W-1:0]    m_tdata
);

    // A held result keeps its value
    `CRH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Ready only drops after an output stall in the previous cycle
    `CRH_ASSERT_SAME(a_ready_cause, aclk, aresetn, !s_tready, $past(m_tvalid && !m_tready), "input ready dropped without an output stall")

    // Once the output drains, the skid slot empties and ready returns
    `CRH_ASSERT_NEXT(a_ready_back, aclk, aresetn, !s_tready && m_tready, s_tready, "input ready did not return after output was taken")

    // Ready cannot stay low while the output side is empty
    `CRH_ASSERT_NEXT(a_no_stall_idle, aclk, aresetn, !m_tvalid, s_tready, "input ready low with an empty output")

endmodule

bind counter_based_random_hash crh_checker u_crh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
